FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is asserted.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/rbst_pkg.sv
// ---------------------------------------------------------------------------
// rbst_pkg
// Types, codes and constants shared by the restart backoff table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package rbst_pkg;

  localparam int unsigned ENTRIES_DEF    = 32;
  localparam int unsigned KEY_BITS_DEF   = 16;
  localparam int unsigned KEY_FIELD_BITS = 16;
  localparam int unsigned REST_BITS      = 16;
  localparam int unsigned DELAY_BITS     = 32;
  localparam int unsigned RETRY_BITS     = 8;
  localparam int unsigned KIND_BITS      = 3;
  localparam int unsigned IN_TDATA_BITS  = 88;
  localparam int unsigned OUT_TDATA_BITS = 56;

  localparam logic [RETRY_BITS-1:0] RETRY_RESET = 8'd10;
  localparam logic [REST_BITS-1:0]  REST_MAX    = 16'hFFFF;
  localparam logic [DELAY_BITS-1:0] DELAY_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    KIND_REGISTER   = 3'd0,
    KIND_UNREGISTER = 3'd1,
    KIND_START_ALL  = 3'd2,
    KIND_STOP_ALL   = 3'd3,
    KIND_EXIT       = 3'd4,
    KIND_QUERY      = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    RS_OK        = 2'd0,
    RS_NOT_FOUND = 2'd1,
    RS_DUPLICATE = 2'd2,
    RS_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    US_STOPPED    = 3'd0,
    US_RUNNING    = 3'd1,
    US_RESTARTING = 3'd2,
    US_FAILED     = 3'd3,
    US_SAFE       = 3'd4
  } ustate_e;

  typedef enum logic [1:0] {
    RES_ZERO   = 2'd0,
    RES_READ   = 2'd1,
    RES_NEW    = 2'd2,
    RES_UPDATE = 2'd3
  } res_src_e;

  // One slot record as held in the data RAM.
  typedef struct packed {
    logic                  critical;
    logic [DELAY_BITS-1:0] max_delay;
    logic [DELAY_BITS-1:0] delay;
    logic [REST_BITS-1:0]  restarts;
    ustate_e               state;
  } rec_t;

  // Controller to datapath.
  typedef struct packed {
    logic     scan_start;
    logic     step;
    logic     alloc;
    logic     release_slot;
    logic     update;
    logic     res_load;
    res_src_e res_src;
    status_e  res_status;
    logic     out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic  last;
    logic  hit;
    logic  free_found;
    logic  out_free;
    kind_e kind;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/rbst_ram.sv
// ---------------------------------------------------------------------------
// rbst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module rbst_ram #(
  parameter int unsigned WIDTH     = 8,
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/rbst_ctrl.sv
// ---------------------------------------------------------------------------
// rbst_ctrl
// Sequencer: scan, decision, slot write-back and result hand-off per item.
// ---------------------------------------------------------------------------
`default_nettype none

module rbst_ctrl
  import rbst_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_fire_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      idle_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_FLUSH  = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_READ   = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_src    = RES_ZERO;
        cmd_o.res_status = RS_OK;
        state_d          = S_FIN;
        case (sts_i.kind)
          KIND_REGISTER: begin
            if (sts_i.hit) begin
              cmd_o.res_load = 1'b0;
              state_d        = S_READ;
            end else if (sts_i.free_found) begin
              cmd_o.alloc   = 1'b1;
              cmd_o.res_src = RES_NEW;
            end else begin
              cmd_o.res_status = RS_FULL;
            end
          end
          KIND_UNREGISTER: begin
            if (sts_i.hit) begin
              cmd_o.release_slot = 1'b1;
            end else begin
              cmd_o.res_status = RS_NOT_FOUND;
            end
          end
          KIND_EXIT: begin
            if (sts_i.hit) begin
              cmd_o.res_load = 1'b0;
              state_d        = S_UPDATE;
            end else begin
              cmd_o.res_status = RS_NOT_FOUND;
            end
          end
          KIND_QUERY: begin
            if (sts_i.hit) begin
              cmd_o.res_load = 1'b0;
              state_d        = S_READ;
            end else begin
              cmd_o.res_status = RS_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_src    = RES_READ;
        cmd_o.res_status = (sts_i.kind == KIND_REGISTER) ? RS_DUPLICATE : RS_OK;
        state_d          = S_FIN;
      end
      S_UPDATE: begin
        cmd_o.update     = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_src    = RES_UPDATE;
        cmd_o.res_status = RS_OK;
        state_d          = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/rbst_dp.sv
// ---------------------------------------------------------------------------
// rbst_dp
// Slot storage, scan pipeline, backoff arithmetic and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module rbst_dp
  import rbst_pkg::*;
#(
  parameter int unsigned ENTRIES  = ENTRIES_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_fire_i,
  input  wire logic [KIND_BITS-1:0]      kind_i,
  input  wire logic [KEY_FIELD_BITS-1:0] unit_key_i,
  input  wire logic [DELAY_BITS-1:0]     min_delay_i,
  input  wire logic [DELAY_BITS-1:0]     max_delay_i,
  input  wire logic                      critical_i,
  input  wire logic [RETRY_BITS-1:0]     max_retries_i,
  input  wire logic                      out_ready_i,
  input  wire cmd_t                      cmd_i,
  output sts_t                           sts_o,
  output logic                           out_valid_o,
  output status_e                        out_status_o,
  output ustate_e                        out_state_o,
  output logic      [REST_BITS-1:0]      out_restarts_o,
  output logic      [DELAY_BITS-1:0]     out_delay_o
);

  localparam int unsigned IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned REC_BITS = $bits(rec_t);

  // Latched item.
  kind_e                 kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [DELAY_BITS-1:0] min_q;
  logic [DELAY_BITS-1:0] max_q;
  logic                  crit_q;
  logic [31:0]           key_ext;

  // Scan control.
  logic [IDX_BITS-1:0] cnt_q;
  logic                pipe_v_q;
  logic [IDX_BITS-1:0] pipe_idx_q;
  logic                hit_q, hit_d;
  logic [IDX_BITS-1:0] hit_idx_q, hit_idx_d;
  logic                free_q, free_d;
  logic [IDX_BITS-1:0] free_idx_q, free_idx_d;
  logic [ENTRIES-1:0]  used_q;

  // RAM ports.
  logic [KEY_BITS-1:0] key_rd;
  logic                key_we;
  logic [IDX_BITS-1:0] raddr;
  rec_t                rec_rd;
  logic [REC_BITS-1:0] rec_rd_bits;
  rec_t                rec_wr;
  logic                rec_we;
  logic [IDX_BITS-1:0] rec_waddr;

  // Backoff arithmetic.
  rec_t                  rec_upd;
  rec_t                  rec_sweep;
  logic [DELAY_BITS-1:0] delay_dbl;
  logic                  pipe_used;
  logic                  sweep_kind;
  logic                  sweep_wr;

  // Result and output registers.
  status_e               res_status_q;
  ustate_e               res_state_q;
  logic [REST_BITS-1:0]  res_rest_q;
  logic [DELAY_BITS-1:0] res_delay_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  ustate_e               out_state_q;
  logic [REST_BITS-1:0]  out_rest_q;
  logic [DELAY_BITS-1:0] out_delay_q;

  assign key_ext = 32'(unit_key_i);
  assign raddr   = cmd_i.step ? cnt_q : hit_idx_q;
  assign key_we  = cmd_i.alloc;

  rbst_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_idx_q),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (key_rd)
  );

  rbst_ram #(
    .WIDTH (REC_BITS),
    .DEPTH (ENTRIES)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wr),
    .raddr_i (raddr),
    .rdata_o (rec_rd_bits)
  );

  assign rec_rd = rec_t'(rec_rd_bits);

  // Pipe stage of the scan: compare for keyed kinds, read-modify-write for sweeps.
  assign pipe_used  = used_q[pipe_idx_q];
  assign sweep_kind = (kind_q == KIND_START_ALL) || (kind_q == KIND_STOP_ALL);
  assign sweep_wr   = pipe_v_q && sweep_kind && pipe_used;

  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (pipe_v_q && !sweep_kind) begin
      if (pipe_used && (key_rd == key_q) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = pipe_idx_q;
      end
      if (!pipe_used && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = pipe_idx_q;
      end
    end
  end

  always_comb begin
    rec_sweep = rec_rd;
    if (kind_q == KIND_STOP_ALL) begin
      rec_sweep.state = US_STOPPED;
    end else if (rec_rd.state == US_STOPPED) begin
      rec_sweep.state = US_RUNNING;
    end
  end

  // Exit event: saturating count, saturating doubling, cap, retry check.
  assign delay_dbl = rec_rd.delay[DELAY_BITS-1] ? DELAY_MAX
                                                : {rec_rd.delay[DELAY_BITS-2:0], 1'b0};

  always_comb begin
    rec_upd          = rec_rd;
    rec_upd.restarts = (rec_rd.restarts == REST_MAX) ? REST_MAX
                                                     : rec_rd.restarts + 1'b1;
    rec_upd.delay    = (delay_dbl > rec_rd.max_delay) ? rec_rd.max_delay : delay_dbl;
    if (rec_upd.restarts > REST_BITS'(max_retries_i)) begin
      rec_upd.state = rec_rd.critical ? US_SAFE : US_FAILED;
    end else begin
      rec_upd.state = US_RESTARTING;
    end
  end

  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = hit_idx_q;
    rec_wr    = rec_upd;
    if (sweep_wr) begin
      rec_we    = 1'b1;
      rec_waddr = pipe_idx_q;
      rec_wr    = rec_sweep;
    end else if (cmd_i.alloc) begin
      rec_we             = 1'b1;
      rec_waddr          = free_idx_q;
      rec_wr.critical    = crit_q;
      rec_wr.max_delay   = max_q;
      rec_wr.delay       = min_q;
      rec_wr.restarts    = '0;
      rec_wr.state       = US_STOPPED;
    end else if (cmd_i.update) begin
      rec_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      kind_q <= kind_e'(kind_i);
      key_q  <= key_ext[KEY_BITS-1:0];
      min_q  <= min_delay_i;
      max_q  <= max_delay_i;
      crit_q <= critical_i;
    end
    pipe_idx_q <= cnt_q;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      case (cmd_i.res_src)
        RES_READ: begin
          res_state_q <= rec_rd.state;
          res_rest_q  <= rec_rd.restarts;
          res_delay_q <= rec_rd.delay;
        end
        RES_NEW: begin
          res_state_q <= US_STOPPED;
          res_rest_q  <= '0;
          res_delay_q <= min_q;
        end
        RES_UPDATE: begin
          res_state_q <= rec_upd.state;
          res_rest_q  <= rec_upd.restarts;
          res_delay_q <= rec_upd.delay;
        end
        default: begin
          res_state_q <= US_STOPPED;
          res_rest_q  <= '0;
          res_delay_q <= '0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_state_q  <= res_state_q;
      out_rest_q   <= res_rest_q;
      out_delay_q  <= res_delay_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pipe_v_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pipe_v_q <= cmd_i.step;
      if (cmd_i.scan_start) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        hit_q  <= hit_d;
        free_q <= free_d;
        if (cmd_i.step) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.alloc) begin
        used_q[free_idx_q] <= 1'b1;
      end
      if (cmd_i.release_slot) begin
        used_q[hit_idx_q] <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.last       = (cnt_q == IDX_BITS'(ENTRIES - 1));
  assign sts_o.hit        = hit_q;
  assign sts_o.free_found = free_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.kind       = kind_q;

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_state_o    = out_state_q;
  assign out_restarts_o = out_rest_q;
  assign out_delay_o    = out_delay_q;

endmodule

`default_nettype wire

FILE: rtl/core/restart_backoff_supervisor_table.sv
// ---------------------------------------------------------------------------
// restart_backoff_supervisor_table: keyed restart table with exponential backoff.
// Each item passes the scan, flush, decide, optional read or update, and finish states.
// One item at a time; a new item is taken once the result has moved to the output register.
// Reset clears all slot valid bits at once; no clearing pass, max_retries goes to 10.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

// Each item runs a linear scan over the slots through the single read port of
// the key RAM, one slot per cycle, looking for the matching key and the lowest
// free slot in the same pass. Start all and stop all use the same scan as a
// read-modify-write sweep over the record RAM. The controller then decides the
// outcome, writes back the slot if needed and loads the result register, which
// passes it on to the output register; that holds it until the downstream side
// takes it. A new item may be taken while that result waits.
module restart_backoff_supervisor_table
  import rbst_pkg::*;
#(
  parameter int unsigned ENTRIES  = ENTRIES_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Configuration: max_retries.
  input  wire logic                      cfg_we_i,
  input  wire logic [RETRY_BITS-1:0]     cfg_wdata_i,
  // Input items.
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // Fields from bit 0: unit_key[15:0], min_delay_ms[47:16], max_delay_ms[79:48],
  // is_critical[80], zero padding[87:81].
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,
  // Fields from bit 0: kind[2:0].
  input  wire logic [KIND_BITS-1:0]      s_axis_tuser_i,
  // Result items.
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  // Fields from bit 0: status[1:0], unit_state[4:2], restart_total[20:5],
  // delay_now_ms[52:21], zero padding[55:53].
  output logic      [OUT_TDATA_BITS-1:0] m_axis_tdata_o
);

  logic [RETRY_BITS-1:0] max_retries_q;
  logic                  in_fire;
  cmd_t                  cmd;
  sts_t                  sts;
  status_e               out_status;
  ustate_e               out_state;
  logic [REST_BITS-1:0]  out_restarts;
  logic [DELAY_BITS-1:0] out_delay;

  // Write the retry limit only while no item is in flight; the block does not check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q <= RETRY_RESET;
    end else if (cfg_we_i) begin
      max_retries_q <= cfg_wdata_i;
    end
  end

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  rbst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .idle_o    (s_axis_tready_o)
  );

  rbst_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .kind_i         (s_axis_tuser_i),
    .unit_key_i     (s_axis_tdata_i[15:0]),
    .min_delay_i    (s_axis_tdata_i[47:16]),
    .max_delay_i    (s_axis_tdata_i[79:48]),
    .critical_i     (s_axis_tdata_i[80]),
    .max_retries_i  (max_retries_q),
    .out_ready_i    (m_axis_tready_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid_o),
    .out_status_o   (out_status),
    .out_state_o    (out_state),
    .out_restarts_o (out_restarts),
    .out_delay_o    (out_delay)
  );

  assign m_axis_tdata_o = {3'b000, out_delay, out_restarts, out_state, out_status};

  // An accepted item keeps the input side closed until its result is loaded into the output register.
  `ASSERT_CLKD(a_one_in_flight, in_fire |=> !s_axis_tready_o, "item accepted while busy")

  // A slot is only allocated when the scan found no match and a free slot.
  `ASSERT_CLKD(a_alloc_ok, cmd.alloc |-> (!sts.hit && sts.free_found), "bad allocation")

  // A result only appears at the end of an item's processing.
  `ASSERT_CLKD(a_result_from_item, $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o),
               "result without an item")

endmodule

`default_nettype wire
